>>> rtl/sprs_pkg.sv
package sprs_pkg;

   // Divider size: one quotient bit is produced per cycle.
   localparam int unsigned DIV_BITS = 18;
   localparam int unsigned DVS_BITS = 26;
   localparam int unsigned CNT_BITS = $clog2(DIV_BITS);

   // Wait numerator is 1000 ms scaled by 256 for the Q6.8 speed.
   localparam logic [DIV_BITS-1:0] WAIT_NUMERATOR = 18'd256000;
   localparam logic [DIV_BITS-1:0] WAIT_MAX       = 18'd256000;

   // Configuration register indexes.
   localparam logic [1:0] REG_HALF_STEP    = 2'd0;
   localparam logic [1:0] REG_STEPS_REV    = 2'd1;
   localparam logic [1:0] REG_TARGET_SPEED = 2'd2;
   localparam logic [1:0] REG_RAMP_STEPS   = 2'd3;

   // Coil drive per phase entry: bit 0 A+, bit 1 A-, bit 2 B+, bit 3 B-.
   localparam logic [3:0] DRIVE_TABLE [8] = '{
      4'h1, 4'h5, 4'h4, 4'h6, 4'h2, 4'hA, 4'h8, 4'h9
   };

   // Commands from the controller to the datapath.
   typedef struct packed {
      logic accept;
      logic div_load_wait;
      logic div_step;
      logic ramp_update;
      logic mult;
      logic out_load;
   } sprs_cmd_type;

   // Status from the datapath to the controller.
   typedef struct packed {
      logic out_free;
   } sprs_status_type;

endpackage

>>> rtl/sprs_ctrl.sv
module sprs_ctrl
   import sprs_pkg::*;
(
   input  logic            clock,
   input  logic            reset,
   input  logic            req_tvalid,
   output logic            req_tready,
   input  sprs_status_type status,
   output sprs_cmd_type    cmd
);

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_DIV_INC,
      ST_RAMP,
      ST_MULT,
      ST_LOAD_WAIT,
      ST_DIV_WAIT,
      ST_FINISH
   } state_type;

   state_type             state_ff, state_in;
   logic [CNT_BITS-1:0]   cnt_ff, cnt_in;

   localparam logic [CNT_BITS-1:0] CNT_LAST = CNT_BITS'(DIV_BITS - 1);

   // Next state, step counter and command decode.
   always_comb begin
      state_in = state_ff;
      cnt_in   = cnt_ff;
      cmd      = '0;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_tvalid) begin
               cmd.accept = 1'b1;
               cnt_in     = '0;
               state_in   = ST_DIV_INC;
            end
         end
         ST_DIV_INC: begin
            cmd.div_step = 1'b1;
            cnt_in       = cnt_ff + 1'b1;
            if (cnt_ff == CNT_LAST) begin
               state_in = ST_RAMP;
            end
         end
         ST_RAMP: begin
            cmd.ramp_update = 1'b1;
            state_in        = ST_MULT;
         end
         ST_MULT: begin
            cmd.mult = 1'b1;
            state_in = ST_LOAD_WAIT;
         end
         ST_LOAD_WAIT: begin
            cmd.div_load_wait = 1'b1;
            cnt_in            = '0;
            state_in          = ST_DIV_WAIT;
         end
         ST_DIV_WAIT: begin
            cmd.div_step = 1'b1;
            cnt_in       = cnt_ff + 1'b1;
            if (cnt_ff == CNT_LAST) begin
               state_in = ST_FINISH;
            end
         end
         ST_FINISH: begin
            if (status.out_free) begin
               cmd.out_load = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   assign req_tready = (state_ff == ST_IDLE);

   // State and counter registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         cnt_ff   <= '0;
      end else begin
         state_ff <= state_in;
         cnt_ff   <= cnt_in;
      end
   end

endmodule

>>> rtl/sprs_datapath.sv
module sprs_datapath
   import sprs_pkg::*;
(
   input  logic            clock,
   input  logic            reset,
   input  sprs_cmd_type    cmd,
   output sprs_status_type status,
   input  logic            half_step_mode,
   input  logic [11:0]     steps_per_rev,
   input  logic [13:0]     target_speed,
   input  logic [7:0]      ramp_steps,
   input  logic            go_reverse,
   input  logic            rsp_tready,
   output logic            rsp_tvalid,
   output logic [39:0]     rsp_tdata
);

   logic [2:0]           phase_ff, phase_in;
   logic [13:0]          ramp_ff, ramp_in;
   logic [3:0]           drive_ff, drive_in;
   logic [DIV_BITS-1:0]  dq_ff, dq_in;
   logic [DVS_BITS-1:0]  rem_ff, rem_in;
   logic [DVS_BITS-1:0]  dvs_ff, dvs_in;
   logic [DVS_BITS-1:0]  prod_ff, prod_in;
   logic                 valid_ff, valid_in;
   logic [39:0]          out_ff, out_in;

   logic [2:0]           entry;
   logic [2:0]           move;
   logic [DVS_BITS:0]    rem_shift;
   logic [DVS_BITS:0]    rem_diff;
   logic                 fits;
   logic [13:0]          inc;
   logic [14:0]          ramp_sum;
   logic [DIV_BITS-1:0]  wait_val;

   // Phase entry and the move to the next one.
   always_comb begin
      entry    = half_step_mode ? phase_ff : (phase_ff | 3'd1);
      move     = half_step_mode ? 3'd1 : 3'd2;
      phase_in = phase_ff;
      drive_in = drive_ff;
      if (cmd.accept) begin
         drive_in = DRIVE_TABLE[entry];
         phase_in = go_reverse ? (entry - move) : (entry + move);
      end
   end

   // Shared restoring divider, one quotient bit per cycle.
   always_comb begin
      rem_shift = {rem_ff, dq_ff[DIV_BITS-1]};
      rem_diff  = rem_shift - {1'b0, dvs_ff};
      fits      = (rem_shift >= {1'b0, dvs_ff});
      dq_in     = dq_ff;
      rem_in    = rem_ff;
      dvs_in    = dvs_ff;
      if (cmd.accept) begin
         dq_in  = DIV_BITS'(target_speed);
         rem_in = '0;
         dvs_in = (ramp_steps == 8'd0) ? DVS_BITS'(1) : DVS_BITS'(ramp_steps);
      end else if (cmd.div_load_wait) begin
         dq_in  = WAIT_NUMERATOR;
         rem_in = '0;
         dvs_in = prod_ff;
      end else if (cmd.div_step) begin
         dq_in  = {dq_ff[DIV_BITS-2:0], fits};
         rem_in = fits ? rem_diff[DVS_BITS-1:0] : rem_shift[DVS_BITS-1:0];
      end
   end

   // Speed ramp, clamped at the target.
   always_comb begin
      inc      = (dq_ff[13:0] == 14'd0) ? 14'd1 : dq_ff[13:0];
      ramp_sum = {1'b0, ramp_ff} + {1'b0, inc};
      ramp_in  = ramp_ff;
      if (cmd.ramp_update) begin
         if (ramp_ff < target_speed) begin
            ramp_in = (ramp_sum > {1'b0, target_speed}) ? target_speed : ramp_sum[13:0];
         end else begin
            ramp_in = target_speed;
         end
      end
   end

   // Divisor of the wait: steps per revolution times speed.
   always_comb begin
      prod_in = prod_ff;
      if (cmd.mult) begin
         prod_in = DVS_BITS'(steps_per_rev) * DVS_BITS'(ramp_ff);
      end
   end

   // Output register; a zero divisor saturates the wait.
   always_comb begin
      wait_val = (prod_ff == '0) ? WAIT_MAX : dq_ff;
      valid_in = valid_ff;
      out_in   = out_ff;
      if (cmd.out_load) begin
         valid_in = 1'b1;
         out_in   = {4'b0, ramp_ff, wait_val, drive_ff};
      end else if (rsp_tready) begin
         valid_in = 1'b0;
      end
   end

   assign status.out_free = !valid_ff || rsp_tready;
   assign rsp_tvalid      = valid_ff;
   assign rsp_tdata       = out_ff;

   // Control state is cleared by reset; payload registers are not.
   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= '0;
         ramp_ff  <= '0;
         valid_ff <= 1'b0;
      end else begin
         phase_ff <= phase_in;
         ramp_ff  <= ramp_in;
         valid_ff <= valid_in;
      end
      drive_ff <= drive_in;
      dq_ff    <= dq_in;
      rem_ff   <= rem_in;
      dvs_ff   <= dvs_in;
      prod_ff  <= prod_in;
      out_ff   <= out_in;
   end

endmodule

>>> rtl/stepper_phase_ramp_sequencer_core.sv
// Each step runs in order: accept, divide for the ramp increment, ramp, multiply,
// divider load, divide for the wait in milliseconds, and output load; the shared
// radix-2 divider runs twice per step. The output load waits until the output
// register is free, and no new request is taken until the step is loaded. A finished
// result waits in the output register while the next request is taken. Reset (synchronous, active high)
// clears phase and speed and loads half step, 48 steps per rev, target 1024, ramp 10.
module stepper_phase_ramp_sequencer_core
   import sprs_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   // Request: bit 0 go_reverse, bits 7:1 zero.
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [7:0]  req_tdata,
   // Response: bit 0 coil_a_pos, 1 coil_a_neg, 2 coil_b_pos, 3 coil_b_neg,
   // 21:4 wait_ms, 35:22 speed_now, 39:36 zero.
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [39:0] rsp_tdata,
   // Configuration port.
   input  logic        csr_psel,
   input  logic        csr_penable,
   input  logic        csr_pwrite,
   input  logic [3:0]  csr_paddr,
   input  logic [31:0] csr_pwdata,
   output logic [31:0] csr_prdata,
   output logic        csr_pready
);

   logic        half_ff, half_in;
   logic [11:0] spr_ff, spr_in;
   logic [13:0] target_ff, target_in;
   logic [7:0]  ramp_steps_ff, ramp_steps_in;
   logic        csr_write;

   sprs_cmd_type    cmd;
   sprs_status_type status;

   assign csr_pready = 1'b1;
   assign csr_write  = csr_psel && csr_penable && csr_pwrite && csr_pready;

   // Register writes.
   always_comb begin
      half_in       = half_ff;
      spr_in        = spr_ff;
      target_in     = target_ff;
      ramp_steps_in = ramp_steps_ff;
      if (csr_write) begin
         unique case (csr_paddr[3:2])
            REG_HALF_STEP:    half_in       = csr_pwdata[0];
            REG_STEPS_REV:    spr_in        = csr_pwdata[11:0];
            REG_TARGET_SPEED: target_in     = csr_pwdata[13:0];
            REG_RAMP_STEPS:   ramp_steps_in = csr_pwdata[7:0];
            default:          half_in       = half_ff;
         endcase
      end
   end

   // Register reads.
   always_comb begin
      unique case (csr_paddr[3:2])
         REG_HALF_STEP:    csr_prdata = {31'b0, half_ff};
         REG_STEPS_REV:    csr_prdata = {20'b0, spr_ff};
         REG_TARGET_SPEED: csr_prdata = {18'b0, target_ff};
         REG_RAMP_STEPS:   csr_prdata = {24'b0, ramp_steps_ff};
         default:          csr_prdata = '0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         half_ff       <= 1'b1;
         spr_ff        <= 12'd48;
         target_ff     <= 14'd1024;
         ramp_steps_ff <= 8'd10;
      end else begin
         half_ff       <= half_in;
         spr_ff        <= spr_in;
         target_ff     <= target_in;
         ramp_steps_ff <= ramp_steps_in;
      end
   end

   sprs_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .status     (status),
      .cmd        (cmd)
   );

   sprs_datapath u_datapath (
      .clock          (clock),
      .reset          (reset),
      .cmd            (cmd),
      .status         (status),
      .half_step_mode (half_ff),
      .steps_per_rev  (spr_ff),
      .target_speed   (target_ff),
      .ramp_steps     (ramp_steps_ff),
      .go_reverse     (req_tdata[0]),
      .rsp_tready     (rsp_tready),
      .rsp_tvalid     (rsp_tvalid),
      .rsp_tdata      (rsp_tdata)
   );

endmodule

>>> rtl/sprs_checker.sv
module sprs_checker (
   input logic        clock,
   input logic        reset,
   input logic        req_tvalid,
   input logic        req_tready,
   input logic        rsp_tvalid,
   input logic        rsp_tready,
   input logic [39:0] rsp_tdata
);

   // A response that is not taken stays and keeps its payload.
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata))
      else $error("response changed while stalled");

   // Once a request transaction is taken, the block is busy in the next cycle.
   a_busy_after_accept: assert property (@(posedge clock) disable iff (reset)
      req_tvalid && req_tready |=> !req_tready)
      else $error("request accepted while a step is in progress");

   // Never both bridge inputs of one coil at once.
   a_no_shoot_through: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> !(rsp_tdata[0] && rsp_tdata[1]) && !(rsp_tdata[2] && rsp_tdata[3]))
      else $error("coil driven both ways");

   // The wait never exceeds its saturation value.
   a_wait_range: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> rsp_tdata[21:4] <= 18'd256000)
      else $error("wait out of range");

   // Reset leaves no response pending.
   a_reset_empty: assert property (@(posedge clock)
      reset |=> !rsp_tvalid)
      else $error("response pending after reset");

endmodule

bind stepper_phase_ramp_sequencer_core sprs_checker u_sprs_checker (
   .clock      (clock),
   .reset      (reset),
   .req_tvalid (req_tvalid),
   .req_tready (req_tready),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata)
);
